[hw/rtl/fcr_pkg.sv]
// Shared types and constants for the frame checksum router.
package fcr_pkg;

	// Frame geometry
	localparam int MAX_FRAME = 4096;
	localparam int HDR_BYTES = 6;
	localparam logic [15:0] LEN_LIMIT = 16'(MAX_FRAME - HDR_BYTES);
	localparam logic [15:0] MAX_PAYLOAD_RST = LEN_LIMIT;

	// Header byte positions (command sits at position 0)
	localparam logic [15:0] POS_SOURCE = 16'd1;
	localparam logic [15:0] POS_DEST   = 16'd2;
	localparam logic [15:0] POS_CSUM   = 16'd3;
	localparam logic [15:0] POS_LEN_A  = 16'd4;
	localparam logic [15:0] POS_PAYLD  = 16'(HDR_BYTES);

	// Command and address codes
	localparam logic [7:0] CMD_NULL     = 8'h00;
	localparam logic [7:0] ADDR_CONTROL = 8'h00;
	localparam logic [7:0] ADDR_SENSOR  = 8'h01;

	// Configuration register indexes
	typedef enum logic {
		CFG_MAX_PAYLOAD      = 1'b0,
		CFG_LENGTH_LOW_FIRST = 1'b1
	} cfg_index_t;

	// Verdict codes
	typedef enum logic [2:0] {
		ST_FORWARD     = 3'd0,
		ST_NULL_CMD    = 3'd1,
		ST_CSUM_ERR    = 3'd2,
		ST_LEN_ERR     = 3'd3,
		ST_UNKNOWN_DST = 3'd4
	} status_t;

	// One finished frame
	typedef struct packed {
		status_t     status;
		logic [7:0]  command;
		logic [7:0]  source;
		logic [7:0]  destination;
		logic [15:0] payload_length;
		logic [7:0]  computed_sum;
	} frame_result_t;

	// Pick the verdict of a frame whose length passed the limit check
	function automatic status_t frame_verdict(logic [7:0] rx_sum, logic [7:0] calc_sum,
			logic [7:0] cmd, logic [7:0] dst);
		status_t st;
		if (rx_sum != calc_sum) begin
			st = ST_CSUM_ERR;
		end else if (cmd == CMD_NULL) begin
			st = ST_NULL_CMD;
		end else if (dst == ADDR_CONTROL || dst == ADDR_SENSOR) begin
			st = ST_FORWARD;
		end else begin
			st = ST_UNKNOWN_DST;
		end
		return st;
	endfunction

endpackage

[hw/rtl/fcr_parser.sv]
// Frame capture state, running checksum and verdict logic for one byte per step.
module fcr_parser (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  logic [7:0]            data_byte,
	input  logic                  frame_start,
	input  logic [15:0]           max_payload,
	input  logic                  length_low_first,
	output logic                  result_valid,
	output fcr_pkg::frame_result_t result
);
	import fcr_pkg::*;

	logic [15:0] pos_q, pos_d;
	logic        in_frame_q, in_frame_d;
	logic        in_payload_q, in_payload_d;
	logic [7:0]  cmd_q, cmd_d;
	logic [7:0]  src_q, src_d;
	logic [7:0]  dst_q, dst_d;
	logic [7:0]  rx_sum_q, rx_sum_d;
	logic [15:0] len_q, len_d;
	logic [7:0]  sum_q, sum_d;
	logic [15:0] len_full;
	logic [15:0] limit;
	logic [7:0]  sum_add;

	// Effective length limit and the running sum with this step's byte added
	assign limit    = (max_payload < LEN_LIMIT) ? max_payload : LEN_LIMIT;
	assign len_full = length_low_first ? (len_q | {data_byte, 8'h00})
	                                   : (len_q | {8'h00, data_byte});
	assign sum_add  = sum_q + data_byte;

	// Advance frame capture by one byte
	always_comb begin
		pos_d        = pos_q;
		in_frame_d   = in_frame_q;
		in_payload_d = in_payload_q;
		cmd_d        = cmd_q;
		src_d        = src_q;
		dst_d        = dst_q;
		rx_sum_d     = rx_sum_q;
		len_d        = len_q;
		sum_d        = sum_q;
		result_valid = 1'b0;
		result       = '{ST_FORWARD, cmd_q, src_q, dst_q, len_q, sum_q};
		if (frame_start) begin
			in_frame_d   = 1'b1;
			in_payload_d = 1'b0;
			cmd_d        = data_byte;
			sum_d        = data_byte;
			pos_d        = POS_SOURCE;
		end else if (in_frame_q) begin
			if (in_payload_q) begin
				sum_d = sum_add;
				pos_d = pos_q - 16'd1;
				if (pos_q == 16'd1) begin
					result_valid = 1'b1;
					result = '{frame_verdict(rx_sum_q, sum_add, cmd_q, dst_q),
					           cmd_q, src_q, dst_q, len_q, sum_add};
					in_frame_d   = 1'b0;
					in_payload_d = 1'b0;
				end
			end else begin
				case (pos_q)
					POS_SOURCE: begin
						src_d = data_byte;
						sum_d = sum_add;
						pos_d = pos_q + 16'd1;
					end
					POS_DEST: begin
						dst_d = data_byte;
						sum_d = sum_add;
						pos_d = pos_q + 16'd1;
					end
					POS_CSUM: begin
						rx_sum_d = data_byte;
						pos_d    = pos_q + 16'd1;
					end
					POS_LEN_A: begin
						len_d = length_low_first ? {8'h00, data_byte} : {data_byte, 8'h00};
						pos_d = pos_q + 16'd1;
					end
					default: begin
						// Second length byte: close the header
						len_d = len_full;
						sum_d = sum_q + len_full[7:0];
						pos_d = POS_PAYLD;
						if (len_full > limit) begin
							result_valid = 1'b1;
							result = '{ST_LEN_ERR, cmd_q, src_q, dst_q, len_full, 8'h00};
							in_frame_d = 1'b0;
						end else if (len_full == 16'd0) begin
							result_valid = 1'b1;
							result = '{frame_verdict(rx_sum_q, sum_d, cmd_q, dst_q),
							           cmd_q, src_q, dst_q, len_full, sum_d};
							in_frame_d   = 1'b0;
							in_payload_d = 1'b0;
						end else begin
							in_payload_d = 1'b1;
							pos_d        = len_full;
						end
					end
				endcase
			end
		end
	end

	// Hold state until a byte is consumed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q        <= '0;
			in_frame_q   <= 1'b0;
			in_payload_q <= 1'b0;
			cmd_q        <= '0;
			src_q        <= '0;
			dst_q        <= '0;
			rx_sum_q     <= '0;
			len_q        <= '0;
			sum_q        <= '0;
		end else if (step) begin
			pos_q        <= pos_d;
			in_frame_q   <= in_frame_d;
			in_payload_q <= in_payload_d;
			cmd_q        <= cmd_d;
			src_q        <= src_d;
			dst_q        <= dst_d;
			rx_sum_q     <= rx_sum_d;
			len_q        <= len_d;
			sum_q        <= sum_d;
		end
	end

endmodule

[hw/rtl/frame_checksum_router.sv]
// Top level of the frame checksum router: input register, parser, result register, config.
//
//  channel | handshake                   | payload
//  --------+-----------------------------+-------------------------------------------
//  s_axis  | s_axis_tvalid/s_axis_tready | tdata: data_byte; tuser: frame_start
//  m_axis  | m_axis_tvalid/m_axis_tready | tdata: cmd,src,dst,length,sum; tuser: status
//  cfg     | cfg_valid/cfg_ready         | cfg_index, cfg_data
//
// One byte per cycle sustained while the result register does not stall; a byte sits in the
// input register; its result, if any, is loaded into the result register on the parser step.
// The parser step (8-bit add, 16-bit length compare) is combinational between the registers.
// arst_n clears frame state and both valid flags; config returns to its reset values.
// A stalled result register holds the byte in the input register; s_axis_tready stays
// high while the input register is empty, or the result register is empty or being taken.
module frame_checksum_router (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
	input  logic        s_axis_tuser,  // [0] frame_start
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,  // [7:0] command, [15:8] source, [23:16] destination,
	                                   // [39:24] payload_length, [47:40] computed_sum
	output logic [2:0]  m_axis_tuser,  // [2:0] status
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);
	import fcr_pkg::*;

	logic          valid_s1;
	logic [7:0]    data_s1;
	logic          start_s1;
	logic          step;
	logic          res_valid;
	frame_result_t res;
	logic          m_valid_q;
	frame_result_t out_q;
	logic [15:0]   max_payload_q;
	logic          len_low_first_q;

	// Consume the registered byte when the result register can take a result
	assign step          = valid_s1 && (!m_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || step;
	assign cfg_ready     = 1'b1;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			data_s1  <= s_axis_tdata;
			start_s1 <= s_axis_tuser;
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_payload_q   <= MAX_PAYLOAD_RST;
			len_low_first_q <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index_t'(cfg_index))
				CFG_MAX_PAYLOAD:      max_payload_q   <= cfg_data;
				CFG_LENGTH_LOW_FIRST: len_low_first_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	fcr_parser u_parser (
		.clk              (clk),
		.arst_n           (arst_n),
		.step             (step),
		.data_byte        (data_s1),
		.frame_start      (start_s1),
		.max_payload      (max_payload_q),
		.length_low_first (len_low_first_q),
		.result_valid     (res_valid),
		.result           (res)
	);

	// Result register: load a new item, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (step && res_valid) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && res_valid) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tuser  = out_q.status;
	assign m_axis_tdata  = {out_q.computed_sum, out_q.payload_length, out_q.destination,
	                        out_q.source, out_q.command};

endmodule

[tb/sv/frame_checksum_router_checker.sv]
`timescale 1ns / 100ps
// Checker for the frame checksum router: predicts each frame verdict and compares results.
module frame_checksum_router_checker
	import fcr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
	input  logic        s_axis_tuser,  // [0] frame_start
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [47:0] m_axis_tdata,  // [7:0] command, [15:8] source, [23:16] destination,
	                                   // [39:24] payload_length, [47:40] computed_sum
	input  logic [2:0]  m_axis_tuser,  // [2:0] status
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	output int          mismatches,
	output int          pending,
	output int          verdicts
);

	// Shadow configuration
	logic [15:0] max_pl;
	logic        lo_first;

	// Shadow deframer state
	logic [15:0] pos;
	logic        in_frame_q;
	logic        in_payload_q;
	logic [7:0]  cmd_q;
	logic [7:0]  src_q;
	logic [7:0]  dst_q;
	logic [7:0]  rx_sum_q;
	logic [15:0] len_q;
	logic [7:0]  sum_q;

	// Verdicts still owed by the block, oldest first
	frame_result_t owed_verdicts[$];

	// Queue one verdict built from the captured header
	task push_verdict(input status_t st, input logic [7:0] sum);
		frame_result_t r;
		r.status         = st;
		r.command        = cmd_q;
		r.source         = src_q;
		r.destination    = dst_q;
		r.payload_length = len_q;
		r.computed_sum   = sum;
		owed_verdicts.push_back(r);
	endtask

	// Rank the checks: checksum, null command, known destination
	task close_frame();
		status_t st;
		if (rx_sum_q != sum_q) begin
			st = ST_CSUM_ERR;
		end else if (cmd_q == CMD_NULL) begin
			st = ST_NULL_CMD;
		end else if (dst_q != ADDR_CONTROL && dst_q != ADDR_SENSOR) begin
			st = ST_UNKNOWN_DST;
		end else begin
			st = ST_FORWARD;
		end
		push_verdict(st, sum_q);
		in_frame_q   = 1'b0;
		in_payload_q = 1'b0;
	endtask

	// Advance the shadow deframer by one accepted item
	task predict_byte(input logic [7:0] d, input logic start);
		logic [15:0] lim;
		if (start) begin
			in_frame_q   = 1'b1;
			in_payload_q = 1'b0;
			cmd_q        = d;
			sum_q        = d;
			pos          = POS_SOURCE;
		end else if (in_frame_q && in_payload_q) begin
			sum_q = sum_q + d;
			pos   = pos - 16'd1;
			if (pos == 16'd0) begin
				close_frame();
			end
		end else if (in_frame_q) begin
			case (pos)
				POS_SOURCE: begin
					src_q = d;
					sum_q = sum_q + d;
					pos   = pos + 16'd1;
				end
				POS_DEST: begin
					dst_q = d;
					sum_q = sum_q + d;
					pos   = pos + 16'd1;
				end
				POS_CSUM: begin
					rx_sum_q = d;
					pos      = pos + 16'd1;
				end
				POS_LEN_A: begin
					len_q = lo_first ? {8'h00, d} : {d, 8'h00};
					pos   = pos + 16'd1;
				end
				default: begin
					// Second length byte closes the header
					lim   = (max_pl < LEN_LIMIT) ? max_pl : LEN_LIMIT;
					len_q = len_q | (lo_first ? {d, 8'h00} : {8'h00, d});
					sum_q = sum_q + len_q[7:0];
					pos   = POS_PAYLD;
					if (len_q > lim) begin
						push_verdict(ST_LEN_ERR, 8'h00);
						in_frame_q = 1'b0;
					end else if (len_q == 16'd0) begin
						close_frame();
					end else begin
						in_payload_q = 1'b1;
						pos          = len_q;
					end
				end
			endcase
		end
	endtask

	// Compare one accepted result with the oldest owed verdict
	task check_result();
		frame_result_t got;
		frame_result_t want;
		got.status         = status_t'(m_axis_tuser);
		got.command        = m_axis_tdata[7:0];
		got.source         = m_axis_tdata[15:8];
		got.destination    = m_axis_tdata[23:16];
		got.payload_length = m_axis_tdata[39:24];
		got.computed_sum   = m_axis_tdata[47:40];
		verdicts++;
		if (owed_verdicts.size() == 0) begin
			mismatches++;
			if (mismatches <= 10) begin
				$display("[%0t] unexpected verdict: status=%0d cmd=%02h src=%02h dst=%02h",
					$realtime, got.status, got.command, got.source, got.destination);
			end
		end else begin
			want = owed_verdicts.pop_front();
			if (got.status !== want.status || got.command !== want.command ||
					got.source !== want.source || got.destination !== want.destination ||
					got.payload_length !== want.payload_length ||
					got.computed_sum !== want.computed_sum) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("[%0t] verdict %0d expected st=%0d cmd=%02h src=%02h dst=%02h len=%04h sum=%02h",
						$realtime, verdicts, want.status, want.command, want.source,
						want.destination, want.payload_length, want.computed_sum);
					$display("[%0t] verdict %0d actual   st=%0d cmd=%02h src=%02h dst=%02h len=%04h sum=%02h",
						$realtime, verdicts, got.status, got.command, got.source,
						got.destination, got.payload_length, got.computed_sum);
				end
			end
		end
	endtask

	// Watch all three channels at each edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_pl       = MAX_PAYLOAD_RST;
			lo_first     = 1'b0;
			pos          = 16'd0;
			in_frame_q   = 1'b0;
			in_payload_q = 1'b0;
			cmd_q        = 8'h00;
			src_q        = 8'h00;
			dst_q        = 8'h00;
			rx_sum_q     = 8'h00;
			len_q        = 16'd0;
			sum_q        = 8'h00;
			owed_verdicts.delete();
			mismatches   = 0;
			pending      = 0;
			verdicts     = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_MAX_PAYLOAD:      max_pl = cfg_data;
					CFG_LENGTH_LOW_FIRST: lo_first = cfg_data[0];
					default: ;
				endcase
			end
			if (m_axis_tvalid && m_axis_tready) begin
				check_result();
			end
			if (s_axis_tvalid && s_axis_tready) begin
				predict_byte(s_axis_tdata, s_axis_tuser);
			end
			pending = owed_verdicts.size();
		end
	end

endmodule

[tb/sv/frame_checksum_router_tb.sv]
`timescale 1ns / 100ps
// Testbench top for the frame checksum router: stimulus, watchdog and final verdict.
module frame_checksum_router_tb;
	import fcr_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 4;
	localparam int IDLE_PCT       = 31;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata  = 8'h00;
	logic        s_axis_tuser  = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b1;
	logic [47:0] m_axis_tdata;
	logic [2:0]  m_axis_tuser;
	logic        cfg_valid     = 1'b0;
	logic        cfg_ready;
	logic        cfg_index     = CFG_MAX_PAYLOAD;
	logic [15:0] cfg_data      = 16'd0;

	int mismatches;
	int pending;
	int verdicts;

	// Stimulus bookkeeping
	logic        idle_on      = 1'b1;
	logic        frame_open   = 1'b0;
	logic [15:0] cur_max      = MAX_PAYLOAD_RST;
	logic        cur_lo_first = 1'b0;
	int          bytes_sent   = 0;
	int          counted      = 0;
	int          reg_writes   = 0;
	int          quiet_cycles = 0;

	frame_checksum_router u_dut (.*);

	frame_checksum_router_checker u_checker (.*);

	// Clock, 20 ns period
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Stall the result side at random while idling is on
	always @(posedge clk) begin
		m_axis_tready <= !idle_on || ($urandom_range(0, 99) >= IDLE_PCT);
	end

	// End the run when nothing moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
					(cfg_valid && cfg_ready)) begin
				quiet_cycles <= 0;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	// Length ceiling as the block applies it
	function automatic logic [15:0] frame_limit();
		return (cur_max < LEN_LIMIT) ? cur_max : LEN_LIMIT;
	endfunction

	// Offer one item, idling first at random, and hold until it is accepted
	task automatic send_byte(input logic [7:0] d, input logic start, input bit counts);
		while (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= d;
		s_axis_tuser  <= start;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		bytes_sent++;
		if (counts) begin
			counted++;
		end
	endtask

	// Drop valid, wait for every owed verdict, then let the pipeline empty
	task automatic hold_quiet();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Write the byte order register, and the payload ceiling first if asked
	task automatic write_config(input bit with_max, input logic [15:0] max_v, input logic lo_v);
		cfg_valid <= 1'b1;
		if (with_max) begin
			cfg_index <= CFG_MAX_PAYLOAD;
			cfg_data  <= max_v;
			@(posedge clk);
			while (!cfg_ready) @(posedge clk);
			cur_max = max_v;
			reg_writes++;
		end
		cfg_index <= CFG_LENGTH_LOW_FIRST;
		cfg_data  <= {15'd0, lo_v};
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid    <= 1'b0;
		cur_lo_first = lo_v;
		reg_writes++;
	endtask

	// Send a whole frame; a bad checksum is always off by a nonzero pattern
	task automatic send_frame(input logic [7:0] cmd, input logic [7:0] src,
			input logic [7:0] dst, input logic [15:0] len, input bit good_sum);
		logic [7:0] body[$];
		logic [7:0] sum;
		logic [7:0] csum;
		sum = cmd + src + dst + len[7:0];
		if (len <= frame_limit()) begin
			for (int i = 0; i < int'(len); i++) begin
				body.push_back(8'($urandom));
				sum = sum + body[i];
			end
		end
		csum = good_sum ? sum : (sum ^ 8'($urandom_range(1, 255)));
		send_byte(cmd, 1'b1, 1'b1);
		send_byte(src, 1'b0, 1'b1);
		send_byte(dst, 1'b0, 1'b1);
		send_byte(csum, 1'b0, 1'b1);
		send_byte(cur_lo_first ? len[7:0] : len[15:8], 1'b0, 1'b1);
		send_byte(cur_lo_first ? len[15:8] : len[7:0], 1'b0, 1'b1);
		foreach (body[i]) begin
			send_byte(body[i], 1'b0, 1'b1);
		end
		frame_open = 1'b0;
	endtask

	// Random frame, checksum sometimes bad, lengths biased small, around and over the ceiling
	task automatic random_frame();
		int         r;
		int         lim;
		int         len;
		logic [7:0] cmd;
		logic [7:0] dst;
		lim = int'(frame_limit());
		r   = $urandom_range(0, 99);
		if (r < 55) begin
			len = $urandom_range(0, (lim < 10) ? lim : 10);
		end else if (r < 70) begin
			len = $urandom_range(0, (lim < 40) ? lim : 40);
		end else if (r < 75) begin
			len = (lim <= 40) ? lim : $urandom_range(0, 40);
		end else if (r < 90) begin
			len = lim + 1 + $urandom_range(0, 2);
		end else begin
			len = $urandom_range(0, 65535) | 'h1000;
		end
		cmd = ($urandom_range(0, 9) == 0) ? CMD_NULL : 8'($urandom);
		r   = $urandom_range(0, 9);
		dst = (r < 4) ? ADDR_CONTROL : (r < 8) ? ADDR_SENSOR : 8'($urandom);
		send_frame(cmd, 8'($urandom), dst, 16'(len), $urandom_range(0, 3) != 0);
	endtask

	// Start a frame and abandon it inside the header
	task automatic broken_header();
		int k;
		k = $urandom_range(1, 5);
		send_byte(8'($urandom), 1'b1, 1'b1);
		for (int i = 1; i < k; i++) begin
			send_byte(8'($urandom), 1'b0, 1'b1);
		end
		frame_open = 1'b1;
	endtask

	// Mix of frames, truncated headers and stray items while idle
	task automatic run_phase(input int n);
		int stop_at;
		int r;
		stop_at = counted + n;
		while (counted < stop_at) begin
			r = $urandom_range(0, 99);
			if (r < 78) begin
				random_frame();
			end else if (r < 90) begin
				broken_header();
			end else if (!frame_open) begin
				repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0, 1'b0);
			end else begin
				random_frame();
			end
		end
		if (frame_open) begin
			random_frame();
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: stray item, extreme header, over-limit length, restart, null command
		send_byte(8'hFF, 1'b0, 1'b0);
		send_frame(8'hFF, 8'hFF, ADDR_SENSOR, 16'h0000, 1'b1);
		send_frame(8'h01, 8'h00, ADDR_CONTROL, 16'hFFFF, 1'b1);
		send_byte(8'h55, 1'b1, 1'b1);
		send_byte(8'hAA, 1'b0, 1'b1);
		send_frame(CMD_NULL, 8'h80, ADDR_CONTROL, 16'h0000, 1'b1);

		// Directed: flip byte order between the two length bytes
		send_byte(8'h3C, 1'b1, 1'b1);
		send_byte(8'h00, 1'b0, 1'b1);
		send_byte(8'h01, 1'b0, 1'b1);
		send_byte(8'h00, 1'b0, 1'b1);
		send_byte(8'hF0, 1'b0, 1'b1);
		hold_quiet();
		write_config(1'b0, 16'd0, 1'b1);
		send_byte(8'hFF, 1'b0, 1'b1);

		// Random phases over several register settings
		hold_quiet();
		write_config(1'b1, 16'hFFFF, 1'b0);
		run_phase(100);
		hold_quiet();
		write_config(1'b1, 16'h0000, 1'b1);
		run_phase(90);
		hold_quiet();
		write_config(1'b1, 16'd30, 1'b0);
		idle_on = 1'b0;
		run_phase(120);
		hold_quiet();
		idle_on = 1'b1;
		write_config(1'b1, 16'd12, 1'b1);
		run_phase(110);
		hold_quiet();
		write_config(1'b1, MAX_PAYLOAD_RST, 1'b0);
		run_phase(130);
		hold_quiet();

		$display("Sent %0d bytes of directed and random frames across %0d register writes;",
			bytes_sent, reg_writes);
		$display("checked %0d verdicts, %0d mismatched, %0d still owed.",
			verdicts, mismatches, pending);
		if (mismatches == 0 && pending == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

[files.f]
hw/rtl/fcr_pkg.sv
hw/rtl/fcr_parser.sv
hw/rtl/frame_checksum_router.sv
tb/sv/frame_checksum_router_checker.sv
tb/sv/frame_checksum_router_tb.sv
